@@ rtl/lpht_pkg.sv @@
// Shared types, codes and constants of the linear-probe hash table.
`timescale 1ns / 1ps

package lpht_pkg;

    // Default storage geometry
    localparam int CAPACITY_DEF   = 1024;
    localparam int KEY_BITS_DEF   = 32;
    localparam int VALUE_BITS_DEF = 32;

    // Fixed field widths of the item channels
    localparam int CMD_W    = 2;
    localparam int KEY_W    = 32;
    localparam int HASH_W   = 32;
    localparam int VALUE_W  = 32;
    localparam int INDEX_W  = 11;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 10;

    // Size register
    localparam int          CFG_W            = 11;
    localparam logic [10:0] TABLE_SIZE_RESET = 11'd1024;
    localparam int          MIN_TABLE_SIZE   = 2;

    // Iterative remainder unit: bits retired per cycle
    localparam int MOD_BITS_PER_STEP = 4;
    localparam int MOD_STEPS         = HASH_W / MOD_BITS_PER_STEP;
    localparam int MOD_CNT_W         = (MOD_STEPS > 1) ? $clog2(MOD_STEPS) : 1;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOOKUP = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_NEXT   = 2'd2
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_FOUND     = 3'd0,
        ST_NOT_FOUND = 3'd1,
        ST_INSERTED  = 3'd2,
        ST_UPDATED   = 3'd3,
        ST_FULL      = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_PROBE,
        S_SCAN,
        S_DONE
    } t_state;

    typedef struct packed {
        t_cmd                cmd;
        logic [KEY_W-1:0]    key;
        logic [HASH_W-1:0]   key_digest;
        logic [VALUE_W-1:0]  value;
        logic [INDEX_W-1:0]  start_index;
    } t_in_item;

    typedef struct packed {
        t_status             status;
        logic [VALUE_W-1:0]  value_out;
        logic [INDEX_W-1:0]  slot_index;
        logic [COUNT_W-1:0]  entry_count;
    } t_out_item;

endpackage

@@ rtl/lpht_mod.sv @@
// Iterative remainder unit: hash mod table size, a few bits per cycle.
`timescale 1ns / 1ps

module lpht_mod #(
    parameter int SZ_W = lpht_pkg::INDEX_W
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [lpht_pkg::HASH_W-1:0] i_dividend,
    input  logic [SZ_W-1:0]             i_divisor,
    output logic                        o_done,
    output logic [SZ_W-1:0]             o_rem
);

    logic                          r_busy;
    logic                          r_done;
    logic [lpht_pkg::MOD_CNT_W-1:0] r_cnt;
    logic [lpht_pkg::HASH_W-1:0]   r_dvd;
    logic [SZ_W-1:0]               r_div;
    logic [SZ_W-1:0]               r_rem;
    logic [SZ_W-1:0]               n_rem;

    // Restoring remainder, one bit per inner step
    always_comb begin
        logic [SZ_W:0]   t;
        logic [SZ_W-1:0] rv;
        rv = r_rem;
        for (int k = 0; k < lpht_pkg::MOD_BITS_PER_STEP; k++) begin
            t = {rv, r_dvd[lpht_pkg::HASH_W-1-k]};
            if (t >= {1'b0, r_div}) begin
                t = t - {1'b0, r_div};
            end
            rv = t[SZ_W-1:0];
        end
        n_rem = rv;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            // Flag done for one cycle after the last step
            r_done <= !i_start && r_busy &&
                      (r_cnt == lpht_pkg::MOD_CNT_W'(lpht_pkg::MOD_STEPS - 1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == lpht_pkg::MOD_CNT_W'(lpht_pkg::MOD_STEPS - 1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_div <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= r_dvd << lpht_pkg::MOD_BITS_PER_STEP;
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

@@ rtl/linear_probe_hash_table_core.sv @@
// Top level of the linear-probe hash table: control, slot memory and item ports.
// Lookup/insert: hash mod size gives the home slot, then probe; the input stalls until the result moves out.
// Hash mod size retires four bits a cycle; the probe reads one slot per cycle.
// Find-next: scan upward from the start index, without wrap, to the first used slot.
// Find-next past the end and unknown commands: answered as not found with no slot read.
// Reset: synchronous; a clearing pass over all CAPACITY slots wipes the used flags, no item taken.
`timescale 1ns / 1ps

module linear_probe_hash_table_core #(
    parameter int CAPACITY   = lpht_pkg::CAPACITY_DEF,
    parameter int KEY_BITS   = lpht_pkg::KEY_BITS_DEF,
    parameter int VALUE_BITS = lpht_pkg::VALUE_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // Configuration: table size
    input  logic                       i_cfg_we,
    input  logic [lpht_pkg::CFG_W-1:0] i_cfg_data,
    // Input items
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  lpht_pkg::t_in_item         i_in_item,
    // Result items
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output lpht_pkg::t_out_item        o_out_item
);

    // Slot index bits and bits for a size / count that can reach CAPACITY
    localparam int IDX_W  = $clog2(CAPACITY);
    localparam int SZ_W   = $clog2(CAPACITY + 1);
    localparam int WORD_W = 1 + KEY_BITS + VALUE_BITS;

    // ------------------------------------------------------------------
    // State
    // ------------------------------------------------------------------
    lpht_pkg::t_state          r_state, n_state;
    logic [lpht_pkg::CFG_W-1:0] r_table_size;

    lpht_pkg::t_cmd            r_cmd;
    logic [KEY_BITS-1:0]       r_key;
    logic [VALUE_BITS-1:0]     r_val;
    logic [SZ_W-1:0]           r_size;
    logic [IDX_W-1:0]          r_idx, n_idx;
    logic [SZ_W-1:0]           r_cnt, n_cnt;     // slots examined so far
    logic [SZ_W-1:0]           r_count, n_count; // stored keys
    logic [IDX_W-1:0]          r_clr;

    lpht_pkg::t_out_item       r_res, n_res;     // finished result, waiting for output reg
    lpht_pkg::t_out_item       r_out;
    logic                      r_out_valid;

    // Slot memory: {used, key, value}, one write port, one registered read port
    logic [WORD_W-1:0]         mem [CAPACITY];
    logic [WORD_W-1:0]         r_rd_data;
    logic                      mem_we, mem_re;
    logic [IDX_W-1:0]          mem_wa, mem_ra;
    logic [WORD_W-1:0]         mem_wd;

    // ------------------------------------------------------------------
    // Helpers
    // ------------------------------------------------------------------
    logic [SZ_W-1:0]           eff_size;
    logic                      accept;
    logic                      mod_start, mod_done;
    logic [SZ_W-1:0]           mod_rem;
    logic                      rd_used, rd_match;
    logic [KEY_BITS-1:0]       rd_key;
    logic [VALUE_BITS-1:0]     rd_val;
    logic [SZ_W-1:0]           idx_p1, cnt_p1, count_p1;
    logic [IDX_W-1:0]          wrap_idx;
    logic                      exhausted, scan_end, has_room;
    logic                      start_in_range;
    logic                      out_free;
    logic [KEY_BITS-1:0]       in_key;
    logic [VALUE_BITS-1:0]     in_val;

    // Clamp the size register to 2..CAPACITY
    always_comb begin
        if (32'(r_table_size) < 32'(lpht_pkg::MIN_TABLE_SIZE)) begin
            eff_size = SZ_W'(lpht_pkg::MIN_TABLE_SIZE);
        end else if (32'(r_table_size) > 32'(CAPACITY)) begin
            eff_size = SZ_W'(CAPACITY);
        end else begin
            eff_size = SZ_W'(r_table_size);
        end
    end

    assign accept         = i_in_valid && (r_state == lpht_pkg::S_IDLE);
    assign o_in_stall     = (r_state != lpht_pkg::S_IDLE);
    assign in_key         = KEY_BITS'(i_in_item.key);
    assign in_val         = VALUE_BITS'(i_in_item.value);
    assign start_in_range = 32'(i_in_item.start_index) < 32'(eff_size);

    // Decode the slot read last cycle
    assign rd_used  = r_rd_data[WORD_W-1];
    assign rd_key   = r_rd_data[WORD_W-2 -: KEY_BITS];
    assign rd_val   = r_rd_data[VALUE_BITS-1:0];
    assign rd_match = rd_used && (rd_key == r_key);

    // Walk arithmetic
    assign idx_p1    = SZ_W'(r_idx) + SZ_W'(1);
    assign wrap_idx  = (idx_p1 == r_size) ? '0 : IDX_W'(idx_p1);
    assign cnt_p1    = r_cnt + SZ_W'(1);
    assign count_p1  = r_count + SZ_W'(1);
    assign exhausted = (cnt_p1 == r_size);
    assign scan_end  = (idx_p1 == r_size);
    assign has_room  = (count_p1 < r_size);

    // Output register frees up when empty or being taken this cycle
    assign out_free = !r_out_valid || !i_out_stall;

    // Start index = hash mod size
    lpht_mod #(
        .SZ_W (SZ_W)
    ) u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (mod_start),
        .i_dividend (i_in_item.key_digest),
        .i_divisor  (eff_size),
        .o_done     (mod_done),
        .o_rem      (mod_rem)
    );

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            lpht_pkg::S_CLEAR: begin
                if (r_clr == IDX_W'(CAPACITY - 1)) begin
                    n_state = lpht_pkg::S_IDLE;
                end
            end
            lpht_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    case (i_in_item.cmd)
                        lpht_pkg::CMD_LOOKUP,
                        lpht_pkg::CMD_INSERT: n_state = lpht_pkg::S_HASH;
                        lpht_pkg::CMD_NEXT: begin
                            n_state = start_in_range ? lpht_pkg::S_SCAN : lpht_pkg::S_DONE;
                        end
                        default: n_state = lpht_pkg::S_DONE;
                    endcase
                end
            end
            lpht_pkg::S_HASH: begin
                if (mod_done) begin
                    n_state = lpht_pkg::S_PROBE;
                end
            end
            lpht_pkg::S_PROBE: begin
                if (!rd_used || rd_match || exhausted) begin
                    n_state = lpht_pkg::S_DONE;
                end
            end
            lpht_pkg::S_SCAN: begin
                if (rd_used || scan_end) begin
                    n_state = lpht_pkg::S_DONE;
                end
            end
            lpht_pkg::S_DONE: begin
                if (out_free) begin
                    n_state = lpht_pkg::S_IDLE;
                end
            end
            default: n_state = lpht_pkg::S_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Per-state actions: memory access, walk registers, result
    // ------------------------------------------------------------------
    always_comb begin
        mem_we    = 1'b0;
        mem_wa    = r_idx;
        mem_wd    = {1'b1, r_key, r_val};
        mem_re    = 1'b0;
        mem_ra    = r_idx;
        mod_start = 1'b0;
        n_idx     = r_idx;
        n_cnt     = r_cnt;
        n_count   = r_count;
        n_res     = r_res;

        case (r_state)
            lpht_pkg::S_CLEAR: begin
                // Wipe one slot per cycle
                mem_we = 1'b1;
                mem_wa = r_clr;
                mem_wd = '0;
            end

            lpht_pkg::S_IDLE: begin
                // Default answer: not found at the effective size
                n_res.status      = lpht_pkg::ST_NOT_FOUND;
                n_res.value_out   = '0;
                n_res.slot_index  = lpht_pkg::INDEX_W'(eff_size);
                n_res.entry_count = lpht_pkg::COUNT_W'(r_count);
                if (accept) begin
                    case (i_in_item.cmd)
                        lpht_pkg::CMD_LOOKUP,
                        lpht_pkg::CMD_INSERT: mod_start = 1'b1;
                        lpht_pkg::CMD_NEXT: begin
                            // Read the first candidate slot right away
                            if (start_in_range) begin
                                mem_re = 1'b1;
                                mem_ra = IDX_W'(i_in_item.start_index);
                                n_idx  = IDX_W'(i_in_item.start_index);
                            end
                        end
                        default: ;
                    endcase
                end
            end

            lpht_pkg::S_HASH: begin
                // Home slot known: issue its read
                if (mod_done) begin
                    mem_re = 1'b1;
                    mem_ra = IDX_W'(mod_rem);
                    n_idx  = IDX_W'(mod_rem);
                    n_cnt  = '0;
                end
            end

            lpht_pkg::S_PROBE: begin
                n_res.value_out   = '0;
                n_res.slot_index  = lpht_pkg::INDEX_W'(r_size);
                n_res.entry_count = lpht_pkg::COUNT_W'(r_count);
                if (rd_match) begin
                    n_res.slot_index = lpht_pkg::INDEX_W'(r_idx);
                    if (r_cmd == lpht_pkg::CMD_INSERT) begin
                        // Update in place
                        mem_we          = 1'b1;
                        n_res.status    = lpht_pkg::ST_UPDATED;
                        n_res.value_out = lpht_pkg::VALUE_W'(r_val);
                    end else begin
                        n_res.status    = lpht_pkg::ST_FOUND;
                        n_res.value_out = lpht_pkg::VALUE_W'(rd_val);
                    end
                end else if (!rd_used) begin
                    if (r_cmd == lpht_pkg::CMD_INSERT) begin
                        if (has_room) begin
                            // Claim the empty slot
                            mem_we            = 1'b1;
                            n_count           = count_p1;
                            n_res.status      = lpht_pkg::ST_INSERTED;
                            n_res.value_out   = lpht_pkg::VALUE_W'(r_val);
                            n_res.slot_index  = lpht_pkg::INDEX_W'(r_idx);
                            n_res.entry_count = lpht_pkg::COUNT_W'(count_p1);
                        end else begin
                            n_res.status = lpht_pkg::ST_FULL;
                        end
                    end else begin
                        n_res.status     = lpht_pkg::ST_NOT_FOUND;
                        n_res.slot_index = lpht_pkg::INDEX_W'(r_idx);
                    end
                end else if (exhausted) begin
                    n_res.status = (r_cmd == lpht_pkg::CMD_INSERT) ?
                                   lpht_pkg::ST_FULL : lpht_pkg::ST_NOT_FOUND;
                end else begin
                    // Advance to the next slot, wrapping at the size
                    mem_re = 1'b1;
                    mem_ra = wrap_idx;
                    n_idx  = wrap_idx;
                    n_cnt  = cnt_p1;
                end
            end

            lpht_pkg::S_SCAN: begin
                n_res.entry_count = lpht_pkg::COUNT_W'(r_count);
                if (rd_used) begin
                    n_res.status     = lpht_pkg::ST_FOUND;
                    n_res.value_out  = lpht_pkg::VALUE_W'(rd_val);
                    n_res.slot_index = lpht_pkg::INDEX_W'(r_idx);
                end else if (scan_end) begin
                    n_res.status     = lpht_pkg::ST_NOT_FOUND;
                    n_res.value_out  = '0;
                    n_res.slot_index = lpht_pkg::INDEX_W'(r_size);
                end else begin
                    // No wrap for the scan
                    mem_re = 1'b1;
                    mem_ra = IDX_W'(idx_p1);
                    n_idx  = IDX_W'(idx_p1);
                end
            end

            lpht_pkg::S_DONE: ;

            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // Slot memory
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            r_rd_data <= mem[mem_ra];
        end
    end

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= lpht_pkg::S_CLEAR;
            r_clr        <= '0;
            r_count      <= '0;
            r_table_size <= lpht_pkg::TABLE_SIZE_RESET;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (r_state == lpht_pkg::S_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end
            if (i_cfg_we) begin
                r_table_size <= i_cfg_data;
            end
            // Hand the finished result to the output register
            if (r_state == lpht_pkg::S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd  <= i_in_item.cmd;
            r_key  <= in_key;
            r_val  <= in_val;
            r_size <= eff_size;
        end
        r_idx <= n_idx;
        r_cnt <= n_cnt;
        r_res <= n_res;
        if (r_state == lpht_pkg::S_DONE && out_free) begin
            r_out <= r_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule
